[rtl/pgm_p5_pkg.sv]
// ----------------------------------------------------------------------------
// pgm_p5_pkg: shared types and constants of the PGM P5 stream parser
// Parse phases, result kinds, error codes and the result word layout.
// ----------------------------------------------------------------------------
package pgm_p5_pkg;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'd0,
        PH_MAG5   = 4'd1,
        PH_MAGNL  = 4'd2,
        PH_HASH   = 4'd3,
        PH_CBODY  = 4'd4,
        PH_WIDTH  = 4'd5,
        PH_HEIGHT = 4'd6,
        PH_MAXV   = 4'd7,
        PH_PIX    = 4'd8,
        PH_MAGP   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_MAGIC  = 3'd1,
        ERR_NO_COMMENT = 3'd2,
        ERR_BAD_NUMBER = 3'd3,
        ERR_NO_NEWLINE = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        NUM_MORE = 2'd0,
        NUM_DONE = 2'd1,
        NUM_BAD  = 2'd2,
        NUM_NONL = 2'd3
    } num_res_t;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int TDATA_OUT_W = 72;

    typedef struct packed {
        kind_t       kind;
        err_t        error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] gray_limit;
        logic [15:0] pixel_value;
        logic        last;
    } result_t;

endpackage

[rtl/pgm_p5_in_stage.sv]
// ----------------------------------------------------------------------------
// pgm_p5_in_stage: input word register
// Holds one accepted byte and its start flag until the parser consumes it.
// ----------------------------------------------------------------------------
module pgm_p5_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       out_free,
    output logic       in_valid,
    output logic       in_sof,
    output logic [7:0] in_byte
);
    logic       valid_reg, valid_next;
    logic       sof_reg;
    logic [7:0] byte_reg;
    logic       accept;

    // Take a new word when the register is empty or drains this cycle.
    assign s_tready = !valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_free) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sof_reg  <= s_tuser;
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_sof   = sof_reg;
    assign in_byte  = byte_reg;

endmodule

[rtl/pgm_p5_core.sv]
// ----------------------------------------------------------------------------
// pgm_p5_core: header parser and pixel counter
// Advances the parse state by one byte per step and forms at most one result.
// ----------------------------------------------------------------------------
module pgm_p5_core #(
    parameter int DIM_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                in_sof,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    output pgm_p5_pkg::result_t res
);
    import pgm_p5_pkg::*;

    localparam logic [19:0] DimMax = 20'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [19:0] MaxvMax = 20'hFFFF;

    phase_t              phase_reg, phase_next;
    logic [15:0]         acc_reg, acc_next;
    logic                digit_reg, digit_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [15:0]         maxval_reg, maxval_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [7:0]          high_reg, high_next;
    logic                bphase_reg, bphase_next;

    phase_t        ph;
    logic          is_digit, is_space, over, wide, empty;
    logic [19:0]   v, limit;
    num_res_t      num;
    logic [15:0]   pix;
    logic [DIM_BITS:0] col_inc, row_inc;

    assign ph       = in_sof ? PH_MAGP : phase_reg;
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_space = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
    assign v        = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {16'd0, 4'(in_byte - CH_ZERO)};
    assign limit    = (ph == PH_MAXV) ? MaxvMax : DimMax;
    assign over     = v > limit;
    assign wide     = maxval_reg[15:8] != 8'd0;
    assign empty    = (width_reg == '0) || (height_reg == '0);
    assign pix      = wide ? {high_reg, in_byte} : {8'd0, in_byte};
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;

    // Classify one byte of a decimal field.
    always_comb begin
        if (is_digit) begin
            num = over ? NUM_BAD : NUM_MORE;
        end else if (!digit_reg) begin
            num = is_space ? NUM_MORE : NUM_BAD;
        end else if (ph == PH_WIDTH) begin
            num = is_space ? NUM_DONE : NUM_BAD;
        end else begin
            num = (in_byte == CH_LF) ? NUM_DONE : NUM_NONL;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        digit_next  = digit_reg;
        width_next  = width_reg;
        height_next = height_reg;
        maxval_next = maxval_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        high_next   = high_reg;
        bphase_next = bphase_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (step) begin
            phase_next = ph;
            unique case (ph)
                PH_MAGP, PH_MAG5, PH_MAGNL, PH_HASH: begin
                    if ((ph == PH_MAGP  && in_byte != CH_P)  ||
                        (ph == PH_MAG5  && in_byte != CH_5)  ||
                        (ph == PH_MAGNL && in_byte != CH_LF) ||
                        (ph == PH_HASH  && in_byte != CH_HASH)) begin
                        phase_next     = PH_WAIT;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = (ph == PH_HASH) ? ERR_NO_COMMENT : ERR_BAD_MAGIC;
                    end else begin
                        unique case (ph)
                            PH_MAGP:  phase_next = PH_MAG5;
                            PH_MAG5:  phase_next = PH_MAGNL;
                            PH_MAGNL: phase_next = PH_HASH;
                            default:  phase_next = PH_CBODY;
                        endcase
                    end
                end
                PH_CBODY: begin
                    if (in_byte == CH_LF) begin
                        phase_next = PH_WIDTH;
                        acc_next   = '0;
                        digit_next = 1'b0;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
                    unique case (num)
                        NUM_MORE: begin
                            if (is_digit) begin
                                acc_next   = v[15:0];
                                digit_next = 1'b1;
                            end
                        end
                        NUM_BAD, NUM_NONL: begin
                            phase_next     = PH_WAIT;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = (num == NUM_BAD) ? ERR_BAD_NUMBER
                                                              : ERR_NO_NEWLINE;
                        end
                        NUM_DONE: begin
                            acc_next   = '0;
                            digit_next = 1'b0;
                            if (ph == PH_WIDTH) begin
                                width_next = acc_reg[DIM_BITS-1:0];
                                phase_next = PH_HEIGHT;
                            end else if (ph == PH_HEIGHT) begin
                                height_next = acc_reg[DIM_BITS-1:0];
                                phase_next  = PH_MAXV;
                            end else begin
                                maxval_next      = acc_reg;
                                col_next         = '0;
                                row_next         = '0;
                                bphase_next      = 1'b0;
                                phase_next       = empty ? PH_WAIT : PH_PIX;
                                res_valid        = 1'b1;
                                res.kind         = KIND_HEADER;
                                res.error_code   = ERR_NONE;
                                res.image_width  = 16'(width_reg);
                                res.image_height = 16'(height_reg);
                                res.gray_limit   = acc_reg;
                                res.last         = empty;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_PIX: begin
                    if (wide && !bphase_reg) begin
                        // Hold the high byte of a big-endian pair.
                        high_next   = in_byte;
                        bphase_next = 1'b1;
                    end else begin
                        bphase_next     = 1'b0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_PIXEL;
                        res.error_code  = ERR_NONE;
                        res.pixel_value = pix;
                        if (col_inc >= {1'b0, width_reg}) begin
                            col_next = '0;
                            row_next = row_inc[DIM_BITS-1:0];
                            if (row_inc >= {1'b0, height_reg}) begin
                                res.last   = 1'b1;
                                phase_next = PH_WAIT;
                            end
                        end else begin
                            col_next = col_inc[DIM_BITS-1:0];
                        end
                    end
                end
                default: phase_next = PH_WAIT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT;
            acc_reg    <= '0;
            digit_reg  <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            maxval_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            high_reg   <= '0;
            bphase_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            digit_reg  <= digit_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            maxval_reg <= maxval_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            high_reg   <= high_next;
            bphase_reg <= bphase_next;
        end
    end

endmodule

[rtl/pgm_p5_out_stage.sv]
// ----------------------------------------------------------------------------
// pgm_p5_out_stage: result word register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pgm_p5_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  pgm_p5_pkg::result_t res,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import pgm_p5_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;
    assign m_tdata  = {5'd0, data_reg.pixel_value, data_reg.gray_limit,
                       data_reg.image_height, data_reg.image_width,
                       data_reg.error_code};

endmodule

[rtl/pgm_p5_stream_parser_unit.sv]
// ----------------------------------------------------------------------------
// pgm_p5_stream_parser_unit: PGM P5 byte stream parser
// Path: an accepted byte waits in the input word register; the parse step
// then loads any result it forms into the result register that drives m_tvalid.
// Throughput: one byte per cycle unless m_tready low stalls the result register.
// Reset: aresetn low clears both word registers and puts the parser in the
// wait phase; bytes are then ignored until one arrives with the start flag.
// ----------------------------------------------------------------------------
// Checks the "P5" line and one comment line, parses width, height and maximum
// gray value, emits one header word, then one pixel word per byte (maximum
// below 256) or per big-endian byte pair. The final pixel carries tlast; a
// header of an empty image carries tlast and ends the file. Any parse error
// emits one error word and drops the rest of the file.
module pgm_p5_stream_parser_unit #(
    parameter int DIM_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_file
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [2:0] error_code, [18:3] image_width,
                                   // [34:19] image_height, [50:35] gray_limit,
                                   // [66:51] pixel_value, [71:67] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);
    import pgm_p5_pkg::*;

    logic       out_free;
    logic       in_valid;
    logic       in_sof;
    logic [7:0] in_byte;
    logic       step;
    logic       res_valid;
    result_t    res;

    pgm_p5_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .in_valid (in_valid),
        .in_sof   (in_sof),
        .in_byte  (in_byte)
    );

    // Advance the parser only when the result register can take its output.
    assign step = in_valid && out_free;

    pgm_p5_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_sof    (in_sof),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    pgm_p5_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
